/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; build with NO_ASSERTIONS defined to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg
// Constants, types and helpers of the Taylor-series sine/cosine core.
// ----------------------------------------------------------------------------
package sct_pkg;

    // Series length: terms per series (valid 4..20).
    localparam int NUM_TERMS = 15;
    localparam int K_W       = $clog2(NUM_TERMS + 1);

    // Angle bounds: 2*pi in Q4.28, 360 degrees in Q10.22.
    localparam logic [31:0] RAD_LIMIT      = 32'd1686629713;
    localparam logic [31:0] DEG_LIMIT      = 32'd1509949440;
    // round(pi/180 * 2^38)
    localparam logic [32:0] DEG_TO_RAD_Q38 = 33'd4797524517;

    // Shared multiplier and accumulator widths.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 32;

    localparam logic [ACC_W-1:0] HALF_S28 = ACC_W'(64'd1 << 27);
    localparam logic [ACC_W-1:0] HALF_S32 = ACC_W'(64'd1 << 31);

    localparam logic [63:0] ONE_Q54   = 64'd1 << 54;
    localparam logic [30:0] ONE_Q30   = 31'd1 << 30;
    localparam logic [63:0] ROUND_Q24 = 64'd1 << 23;

    // round(2^32 / (m*(m+1))) for m = 1..38, entry m-1; covers NUM_TERMS up to 20.
    localparam int RECIP_DEPTH = 38;
    localparam int RIDX_W      = $clog2(RECIP_DEPTH);
    localparam logic [31:0] RECIP_TAB [0:RECIP_DEPTH-1] = '{
        32'd2147483648, 32'd715827883, 32'd357913941, 32'd214748365,
        32'd143165577,  32'd102261126, 32'd76695845,  32'd59652324,
        32'd47721859,   32'd39045157,  32'd32537631,  32'd27531842,
        32'd23598721,   32'd20452225,  32'd17895697,  32'd15790321,
        32'd14035841,   32'd12558384,  32'd11302546,  32'd10226113,
        32'd9296466,    32'd8488078,   32'd7780738,   32'd7158279,
        32'd6607642,    32'd6118187,   32'd5681174,   32'd5289369,
        32'd4936744,    32'd4618244,   32'd4329604,   32'd4067204,
        32'd3827957,    32'd3609216,   32'd3408704,   32'd3224450,
        32'd3054742,    32'd2898089
    };

    // Accumulate-stage operation and destination.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LO,      // low partial product, plus rounding half
        OP_HI,      // high partial product, finish and round
        OP_ONE      // single product, round
    } acc_op_t;

    typedef enum logic [1:0] {
        DST_XM,
        DST_X2,
        DST_CT,
        DST_ST
    } acc_dst_t;

    typedef struct packed {
        acc_op_t  op;
        logic     wide_shift;   // 1: shift by 32, 0: shift by 28
        acc_dst_t dst;
        logic     sum_upd;      // term is final for this index
        logic     sum_sub;      // subtract from running sum
    } acc_ctl_t;

    typedef struct packed {
        logic add_c;
        logic add_s;
        logic sub;
    } sum_ctl_t;

    // Q.54 two's complement sum to saturated Q2.30, magnitude rounded half away.
    function automatic logic [31:0] to_q30(input logic [63:0] sum, input logic negate);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] rnd;
        logic [39:0] r;
        logic [30:0] sat;
        neg = sum[63];
        mag = neg ? (64'd0 - sum) : sum;
        rnd = mag + ROUND_Q24;
        r   = rnd[63:24];
        sat = (r > 40'(ONE_Q30)) ? ONE_Q30 : r[30:0];
        neg = neg ^ negate;
        return neg ? (32'd0 - {1'b0, sat}) : {1'b0, sat};
    endfunction

endpackage

/* rtl/core/sine_cosine_taylor.sv */
// ----------------------------------------------------------------------------
// sine_cosine_taylor
// One beat at a time: s_tready is high only while the sequencer is idle, so a new
//   beat waits until the previous result is loaded into the output register.
// All products share one 34x34 multiplier: two partial products per term product,
//   four per term; degree mode adds a degrees-to-radians product before x^2.
// Reset: asynchronous, active low; returns to idle, drops m_tvalid, radian mode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sine_cosine_taylor
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration: degree_mode
    input  logic        cfg_we,
    input  logic        cfg_wdata,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] angle (signed)

    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [31:0] sine_value, [63:32] cosine_value
    output logic [0:0]  m_tuser     // [0] angle_clipped
);

    // ------------------------------------------------------------------------
    // Sequencer
    //   IDLE     take a beat, fold sign and clip the magnitude
    //   DEG      degrees to radians on the multiplier (degree mode only)
    //   SQ       x^2 = round(x*x / 2^28)
    //   INIT     seed terms and sums: sine x, cosine 1
    //   LOOP     8 steps per term index k = 2..NUM_TERMS:
    //              step[2] 0: term * reciprocal, 1: term * x^2
    //              step[1] 0: cosine, 1: sine
    //              step[0] 0: low 32 bits of term, 1: high 32 bits
    //   DRAIN    last accumulate in flight
    //   FLUSH    last sum update in flight
    //   FINAL    round both sums to Q2.30 into the output register
    // The multiplier output is registered; the accumulate runs in the cycle after
    // the multiply and the sum update in the cycle after the accumulate. Cosine and
    // sine alternate so each result is back before its next product starts.
    // ------------------------------------------------------------------------
    typedef enum logic [3:0] {
        S_IDLE,
        S_DEG,
        S_DEG_WAIT,
        S_SQ,
        S_SQ_WAIT,
        S_INIT,
        S_LOOP,
        S_DRAIN,
        S_FLUSH,
        S_FINAL
    } state_t;

    state_t                state_reg, state_next;
    logic [2:0]            step_reg, step_next;
    logic [sct_pkg::K_W-1:0] k_reg, k_next;
    sct_pkg::acc_ctl_t     acc_ctl_reg, acc_ctl_next;
    sct_pkg::sum_ctl_t     sum_ctl_reg, sum_ctl_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic                  degree_mode_reg, degree_mode_next;
    logic                  load_out;

    // Datapath registers
    logic                        neg_reg;
    logic                        clip_reg;
    logic [30:0]                 mag_reg;
    logic [30:0]                 xm_reg;
    logic [33:0]                 x2_reg;
    logic [63:0]                 c_term_reg;
    logic [63:0]                 s_term_reg;
    logic [63:0]                 c_sum_reg;
    logic [63:0]                 s_sum_reg;
    logic [sct_pkg::PROD_W-1:0]  prod_reg;
    logic [sct_pkg::ACC_W-1:0]   acc_reg;
    logic [63:0]                 m_tdata_reg;
    logic                        m_tuser_reg;

    // Input folding
    logic        in_neg;
    logic [31:0] in_abs;
    logic [31:0] in_lim;
    logic        in_clip;
    logic [31:0] in_mag;

    // Multiplier and accumulate
    logic [sct_pkg::MUL_W-1:0]   mul_a;
    logic [sct_pkg::MUL_W-1:0]   mul_b;
    logic [63:0]                 term_sel;
    logic [sct_pkg::RIDX_W-1:0]  recip_idx;
    logic [sct_pkg::ACC_W-1:0]   add_a;
    logic [sct_pkg::ACC_W-1:0]   add_b;
    logic [sct_pkg::ACC_W-1:0]   acc_full;
    logic [63:0]                 acc_res;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Magnitude of the angle, saturated at one full turn
    always_comb
    begin
        in_neg  = s_tdata[31];
        in_abs  = in_neg ? (32'd0 - s_tdata) : s_tdata;
        in_lim  = degree_mode_reg ? sct_pkg::DEG_LIMIT : sct_pkg::RAD_LIMIT;
        in_clip = (in_abs > in_lim);
        in_mag  = in_clip ? in_lim : in_abs;
    end

    // Control
    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        k_next           = k_reg;
        acc_ctl_next     = '{op: sct_pkg::OP_NONE, wide_shift: 1'b0, dst: sct_pkg::DST_XM,
                             sum_upd: 1'b0, sum_sub: 1'b0};
        load_out         = 1'b0;
        m_tvalid_next    = (m_tvalid_reg && m_tready) ? 1'b0 : m_tvalid_reg;
        degree_mode_next = cfg_we ? cfg_wdata : degree_mode_reg;

        // A finished term feeds its running sum in the next cycle
        sum_ctl_next.add_c = (acc_ctl_reg.op == sct_pkg::OP_HI) && acc_ctl_reg.sum_upd &&
                             (acc_ctl_reg.dst == sct_pkg::DST_CT);
        sum_ctl_next.add_s = (acc_ctl_reg.op == sct_pkg::OP_HI) && acc_ctl_reg.sum_upd &&
                             (acc_ctl_reg.dst == sct_pkg::DST_ST);
        sum_ctl_next.sub   = acc_ctl_reg.sum_sub;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = degree_mode_reg ? S_DEG : S_SQ;
                end
            end
            S_DEG:
            begin
                acc_ctl_next.op         = sct_pkg::OP_ONE;
                acc_ctl_next.wide_shift = 1'b1;
                acc_ctl_next.dst        = sct_pkg::DST_XM;
                state_next              = S_DEG_WAIT;
            end
            S_DEG_WAIT:
            begin
                state_next = S_SQ;
            end
            S_SQ:
            begin
                acc_ctl_next.op         = sct_pkg::OP_ONE;
                acc_ctl_next.wide_shift = 1'b0;
                acc_ctl_next.dst        = sct_pkg::DST_X2;
                state_next              = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                state_next = S_INIT;
            end
            S_INIT:
            begin
                step_next  = 3'd0;
                k_next     = sct_pkg::K_W'(2);
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                acc_ctl_next.op         = step_reg[0] ? sct_pkg::OP_HI : sct_pkg::OP_LO;
                acc_ctl_next.wide_shift = ~step_reg[2];
                acc_ctl_next.dst        = step_reg[1] ? sct_pkg::DST_ST : sct_pkg::DST_CT;
                acc_ctl_next.sum_upd    = step_reg[2];
                acc_ctl_next.sum_sub    = ~k_reg[0];    // even index subtracts
                step_next               = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    if (k_reg == sct_pkg::K_W'(sct_pkg::NUM_TERMS))
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        k_next = k_reg + sct_pkg::K_W'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                // wait for the previous result to leave the output register
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= 3'd0;
            k_reg           <= '0;
            acc_ctl_reg     <= '{op: sct_pkg::OP_NONE, wide_shift: 1'b0, dst: sct_pkg::DST_XM,
                                 sum_upd: 1'b0, sum_sub: 1'b0};
            sum_ctl_reg     <= '0;
            m_tvalid_reg    <= 1'b0;
            degree_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            k_reg           <= k_next;
            acc_ctl_reg     <= acc_ctl_next;
            sum_ctl_reg     <= sum_ctl_next;
            m_tvalid_reg    <= m_tvalid_next;
            degree_mode_reg <= degree_mode_next;
        end
    end

    // Operand select for the shared multiplier.
    // Reciprocal index m-1: cosine m = 2k-3, sine m = 2k-2.
    always_comb
    begin
        term_sel  = step_reg[1] ? s_term_reg : c_term_reg;
        recip_idx = sct_pkg::RIDX_W'({k_reg, 1'b0}) - sct_pkg::RIDX_W'(step_reg[1] ? 3 : 4);
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            S_DEG:
            begin
                mul_a = sct_pkg::MUL_W'(mag_reg);
                mul_b = sct_pkg::MUL_W'(sct_pkg::DEG_TO_RAD_Q38);
            end
            S_SQ:
            begin
                mul_a = sct_pkg::MUL_W'(xm_reg);
                mul_b = sct_pkg::MUL_W'(xm_reg);
            end
            S_LOOP:
            begin
                mul_a = step_reg[0] ? sct_pkg::MUL_W'(term_sel[63:32])
                                    : sct_pkg::MUL_W'(term_sel[31:0]);
                mul_b = step_reg[2] ? x2_reg : sct_pkg::MUL_W'(sct_pkg::RECIP_TAB[recip_idx]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Accumulate: low or single product plus rounding half, then high partial shifted up.
    always_comb
    begin
        if (acc_ctl_reg.op == sct_pkg::OP_HI)
        begin
            add_a = acc_reg;
            add_b = {prod_reg, 32'd0};
        end
        else
        begin
            add_a = acc_ctl_reg.wide_shift ? sct_pkg::HALF_S32 : sct_pkg::HALF_S28;
            add_b = sct_pkg::ACC_W'(prod_reg);
        end
        acc_full = add_a + add_b;
        acc_res  = acc_ctl_reg.wide_shift ? acc_full[95:32] : acc_full[91:28];
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (s_tvalid && s_tready)
        begin
            neg_reg  <= in_neg;
            clip_reg <= in_clip;
            mag_reg  <= in_mag[30:0];
            xm_reg   <= in_mag[30:0];
        end

        if (acc_ctl_reg.op == sct_pkg::OP_LO)
        begin
            acc_reg <= acc_full;
        end
        else if (acc_ctl_reg.op != sct_pkg::OP_NONE)
        begin
            unique case (acc_ctl_reg.dst)
                sct_pkg::DST_XM:
                begin
                    // converted angle overshoot holds at 2*pi
                    xm_reg <= (acc_res > 64'(sct_pkg::RAD_LIMIT)) ? sct_pkg::RAD_LIMIT[30:0]
                                                                  : acc_res[30:0];
                end
                sct_pkg::DST_X2: x2_reg     <= acc_res[33:0];
                sct_pkg::DST_CT: c_term_reg <= acc_res;
                sct_pkg::DST_ST: s_term_reg <= acc_res;
            endcase
        end

        if (state_reg == S_INIT)
        begin
            c_term_reg <= sct_pkg::ONE_Q54;
            s_term_reg <= {7'd0, xm_reg, 26'd0};
            c_sum_reg  <= sct_pkg::ONE_Q54;
            s_sum_reg  <= {7'd0, xm_reg, 26'd0};
        end
        else
        begin
            if (sum_ctl_reg.add_c)
            begin
                c_sum_reg <= sum_ctl_reg.sub ? (c_sum_reg - c_term_reg) : (c_sum_reg + c_term_reg);
            end
            if (sum_ctl_reg.add_s)
            begin
                s_sum_reg <= sum_ctl_reg.sub ? (s_sum_reg - s_term_reg) : (s_sum_reg + s_term_reg);
            end
        end

        if (load_out)
        begin
            m_tdata_reg <= {sct_pkg::to_q30(c_sum_reg, 1'b0), sct_pkg::to_q30(s_sum_reg, neg_reg)};
            m_tuser_reg <= clip_reg;
        end
    end

    // Assertions
    `ASSERT_ALWAYS(a_hi_after_lo, clk, rst_n, (acc_ctl_reg.op == sct_pkg::OP_HI) |-> ($past(acc_ctl_reg.op) == sct_pkg::OP_LO), "high partial without low partial")
    `ASSERT_ALWAYS(a_sum_after_hi, clk, rst_n, (sum_ctl_reg.add_c || sum_ctl_reg.add_s) |-> ($past(acc_ctl_reg.op) == sct_pkg::OP_HI), "sum update without finished term")
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, s_tvalid && s_tready, state_reg != S_IDLE, "accepted beat left sequencer idle")
    `ASSERT_ALWAYS(a_final_drained, clk, rst_n, (state_reg == S_FINAL) |-> ((acc_ctl_reg.op == sct_pkg::OP_NONE) && !sum_ctl_reg.add_c && !sum_ctl_reg.add_s), "result taken with work in flight")

endmodule

/* tb/sv/tb_sine_cosine_taylor.sv */
// ----------------------------------------------------------------------------
// tb_sine_cosine_taylor
// Self-checking bench for the Taylor-series sine/cosine core: a clocked driver
// feeds angle beats from a queue, a clocked monitor predicts each accepted
// beat at full 128-bit product width and checks every result beat in order,
// across radian and degree mode and several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_sine_cosine_taylor;

    // Angle bounds and degree scale: 2*pi in Q4.28, 360 deg in Q10.22,
    // round(pi/180 * 2^38).
    localparam logic [31:0] RAD_BOUND     = 32'd1686629713;
    localparam logic [31:0] DEG_BOUND     = 32'd1509949440;
    localparam logic [63:0] DEG_SCALE_Q38 = 64'd4797524517;

    localparam int PHASE_ITEMS = 166;
    // Beyond the worst latency of the core (degree mode).
    localparam int SETTLE_CYCLES = 250;

    typedef struct packed {
        logic [31:0] sine;
        logic [31:0] cosine;
        logic        clipped;
    } trig_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'd0;    // [31:0] angle (signed)
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;              // [31:0] sine_value, [63:32] cosine_value
    logic [0:0]  m_tuser;              // [0] angle_clipped

    // Bench state
    logic [31:0]  pending_angles[$];   // filled by the stimulus block
    trig_result_t expected_trig[$];    // predictions, oldest first
    logic         angle_taken    = 1'b0;  // input beat accepted at last rising edge
    logic         degree_mode_now = 1'b0; // mirror of the mode register
    int           send_idle_pct  = 0;
    int           stall_pct      = 0;
    int           mismatch_count = 0;

    sine_cosine_taylor dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // round(a*b / 2^s), halves up, on the full 128-bit product; low 64 bits kept
    function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b,
                                              input int unsigned s);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        p = p + (128'd1 << (s - 1));
        p = p >> s;
        return p[63:0];
    endfunction

    // 1/(m(m+1)) in Q0.32, rounded to nearest
    function automatic logic [63:0] pair_recip(input int unsigned m);
        logic [63:0] d;
        d = 64'(m) * 64'(m + 1);
        return ((64'd1 << 32) + d / 2) / d;
    endfunction

    // Q.54 sum to saturated Q2.30: magnitude rounded half away from zero
    function automatic logic [31:0] to_q2_30(input logic [63:0] acc, input logic flip);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] r;
        neg = acc[63];
        mag = neg ? (64'd0 - acc) : acc;
        r   = (mag + (64'd1 << 23)) >> 24;
        if (r > (64'd1 << 30))
            r = 64'd1 << 30;
        neg = neg ^ flip;
        return neg ? 32'(64'd0 - r) : r[31:0];
    endfunction

    function automatic trig_result_t predict_trig(input logic [31:0] angle,
                                                  input logic in_degrees);
        trig_result_t res;
        logic         neg;
        logic [63:0]  mag;
        logic [63:0]  bound;
        logic [63:0]  xm;
        logic [63:0]  x2;
        logic [63:0]  s_term;
        logic [63:0]  c_term;
        logic [63:0]  s_sum;
        logic [63:0]  c_sum;
        neg   = angle[31];
        mag   = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
        bound = {32'd0, in_degrees ? DEG_BOUND : RAD_BOUND};
        res.clipped = (mag > bound);
        if (res.clipped)
            mag = bound;
        if (in_degrees)
        begin
            xm = round_mul(mag, DEG_SCALE_Q38, 32);
            // 360 deg may convert slightly past 2*pi: held, flag untouched
            if (xm > {32'd0, RAD_BOUND})
                xm = {32'd0, RAD_BOUND};
        end
        else
            xm = mag;
        x2 = round_mul(xm, xm, 28);

        // terms in Q.54; each from the last via x^2/(m(m+1))
        s_term = xm << 26;
        c_term = 64'd1 << 54;
        s_sum  = s_term;
        c_sum  = c_term;
        for (int k = 2; k <= sct_pkg::NUM_TERMS; k++)
        begin
            c_term = round_mul(round_mul(c_term, pair_recip(2 * k - 3), 32), x2, 28);
            s_term = round_mul(round_mul(s_term, pair_recip(2 * k - 2), 32), x2, 28);
            if (k % 2 == 1)
            begin
                c_sum = c_sum + c_term;
                s_sum = s_sum + s_term;
            end
            else
            begin
                c_sum = c_sum - c_term;
                s_sum = s_sum - s_term;
            end
        end

        // odd function: sine follows the sign of the angle, cosine does not
        res.sine   = to_q2_30(s_sum, neg);
        res.cosine = to_q2_30(c_sum, 1'b0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: all inputs move on the falling edge. A new angle beat is offered
    // only once the previous one went through, so tvalid never dips between
    // back-to-back beats.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic        next_valid;
        logic [31:0] next_angle;
        next_valid = s_tvalid;
        next_angle = s_tdata;
        if (!rst_n)
            next_valid = 1'b0;
        else if (!s_tvalid || angle_taken)
        begin
            next_valid = 1'b0;
            if (pending_angles.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_valid = 1'b1;
                next_angle = pending_angles.pop_front();
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_angle;
        m_tready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor: samples both handshakes at the rising edge. Prediction uses the
    // mode mirror, which only changes while nothing is in flight.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        trig_result_t got;
        trig_result_t want;
        angle_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            expected_trig.push_back(predict_trig(s_tdata, degree_mode_now));
        if (rst_n && m_tvalid && m_tready)
        begin
            got.sine    = m_tdata[31:0];
            got.cosine  = m_tdata[63:32];
            got.clipped = m_tuser[0];
            if (expected_trig.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: sin %0d cos %0d clip %0b",
                             $signed(got.sine), $signed(got.cosine), got.clipped);
            end
            else
            begin
                want = expected_trig.pop_front();
                if (got !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: sin %0d/%0d cos %0d/%0d clip %0b/%0b (exp/got)",
                                 $signed(want.sine), $signed(got.sine),
                                 $signed(want.cosine), $signed(got.cosine),
                                 want.clipped, got.clipped);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Random angle: mostly in range, plus full-width noise, tiny angles and
    // values hugging the saturation bound from both sides.
    function automatic logic [31:0] random_angle(input logic in_degrees);
        logic [31:0] bound;
        logic [31:0] a;
        int unsigned pick;
        bound = in_degrees ? DEG_BOUND : RAD_BOUND;
        pick  = $urandom_range(0, 99);
        if (pick < 55)
            a = $urandom_range(0, bound << 1) - bound;
        else if (pick < 70)
            a = $urandom;
        else if (pick < 85)
            a = $urandom_range(0, 32'd1 << 20);
        else
            a = bound - 32'd8 + $urandom_range(0, 16);
        if (pick >= 70 && $urandom_range(0, 1) == 1)
            a = 32'd0 - a;
        return a;
    endfunction

    // Register write with the core idle; the mirror follows right away.
    task automatic write_mode(input logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        degree_mode_now = v;
    endtask

    // Wait for every queued beat to be sent and every result to come back.
    task automatic drain();
        while (pending_angles.size() != 0 || s_tvalid || expected_trig.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed, radians: zero, smallest steps, bounds, just past bounds,
        // most positive/negative codes, quarter and half turns.
        write_mode(1'b0);
        pending_angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, RAD_BOUND, 32'd0 - RAD_BOUND,
                           RAD_BOUND + 32'd1, 32'd0 - (RAD_BOUND + 32'd1),
                           32'h7FFF_FFFF, 32'h8000_0000,
                           32'd421657428, 32'd843314857, 32'd0 - 32'd843314857};
        drain();

        // Directed, degrees: 360 deg is where the conversion may overshoot 2*pi.
        write_mode(1'b1);
        pending_angles = '{32'd0, 32'd377487360, 32'd0 - 32'd377487360,
                           DEG_BOUND, 32'd0 - DEG_BOUND, DEG_BOUND + 32'd1,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
        drain();

        // Random phases: both modes under each idling mix.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase / 2)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            write_mode(phase % 2 == 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_angles.push_back(random_angle(degree_mode_now));
            drain();
        end

        // Anything arriving now is an extra beat and gets flagged.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_trig.size() == 0)
            $display("sine_cosine_taylor test passed");
        else
            $display("sine_cosine_taylor test failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #4000000;
        $display("sine_cosine_taylor test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/sct_pkg.sv
rtl/core/sine_cosine_taylor.sv
tb/sv/tb_sine_cosine_taylor.sv
